// ===== rtl/lcg48_bounded_random_top_defines.svh =====
// Assertion macros for the lcg48 bounded random generator.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef LCG48_BOUNDED_RANDOM_TOP_DEFINES_SVH
`define LCG48_BOUNDED_RANDOM_TOP_DEFINES_SVH

// Same-cycle implication.
`define LBR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lbr assertion failed");

// Next-cycle implication.
`define LBR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lbr assertion failed");

`endif

// ===== rtl/lbr_pkg.sv =====
// Shared types and constants for the lcg48 bounded random generator.
// No dependencies.
`default_nettype none

package lbr_pkg;

  localparam int STATE_BITS = 48;
  localparam int MUL_CHUNK  = 16;

  localparam logic [STATE_BITS-1:0] RESET_MULT = 48'h0005_DEEC_E66D;
  localparam logic [STATE_BITS-1:0] RESET_ADD  = 48'h0000_0000_000B;

  // Last try index before the remainder is taken anyway (cap of 1024).
  localparam logic [9:0] LAST_TRY = 10'd1023;

  localparam logic [1:0] OP_RAW   = 2'd0;
  localparam logic [1:0] OP_LIMIT = 2'd1;
  localparam logic [1:0] OP_LONG  = 2'd2;
  localparam logic [1:0] OP_RANGE = 2'd3;

  localparam logic [1:0] REG_SEED = 2'd0;
  localparam logic [1:0] REG_MULT = 2'd1;
  localparam logic [1:0] REG_ADD  = 2'd2;

  typedef enum logic [1:0] {
    K_RAW,
    K_LONG,
    K_LIMIT,
    K_CONST
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [5:0]  width;   // effective raw width, 0..32
    logic [30:0] limit;   // exclusive limit for limited draws
    logic        pow2;
    logic [4:0]  shamt;   // 31 - log2(limit) when pow2
    logic [31:0] offset;  // added to limited result; constant value for K_CONST
    logic        bad;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic start;
    logic busy;
  } back_stat_t;

endpackage

`default_nettype wire

// ===== rtl/lbr_front.sv =====
// Request decoder: splits the request word and classifies it into a command.
// Depends on lbr_pkg.
`default_nettype none

module lbr_front (
  input  wire logic [103:0] req_i,
  output lbr_pkg::cmd_t     cmd_o
);
  import lbr_pkg::*;

  logic [1:0]  op;
  logic [5:0]  bc;
  logic [31:0] ub, lo, hi, span, lim, lim_m1;
  logic        lim_ok;
  logic [4:0]  k;

  assign op = req_i[1:0];
  assign bc = req_i[7:2];
  assign ub = req_i[39:8];
  assign lo = req_i[71:40];
  assign hi = req_i[103:72];

  assign span   = hi - lo + 32'd1;
  assign lim    = (op == OP_LIMIT) ? ub : span;
  assign lim_m1 = lim - 32'd1;
  assign lim_ok = (lim != 32'd0) && !lim[31];

  always_comb begin
    k = 5'd0;
    for (int i = 0; i < 31; i++) begin
      if (lim[i]) k = 5'(i);
    end
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.kind   = K_CONST;
    cmd_o.width  = (bc > 6'd32) ? 6'd32 : bc;
    cmd_o.limit  = lim[30:0];
    cmd_o.pow2   = ((lim & lim_m1) == 32'd0);
    cmd_o.shamt  = 5'd31 - k;
    unique case (op)
      OP_RAW:  cmd_o.kind = K_RAW;
      OP_LONG: cmd_o.kind = K_LONG;
      OP_LIMIT: begin
        if (lim_ok) cmd_o.kind = K_LIMIT;
        else cmd_o.bad = 1'b1;
      end
      default: begin
        if ($signed(lo) >= $signed(hi)) begin
          cmd_o.offset = lo;
        end else if (lim_ok) begin
          cmd_o.kind   = K_LIMIT;
          cmd_o.offset = lo;
        end else begin
          cmd_o.bad = 1'b1;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/lbr_queue.sv =====
// Two-entry command queue between decoder and generator engine.
// Depends on lbr_pkg.
`default_nettype none

module lbr_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  lbr_pkg::cmd_t        data_i,
  input  wire logic            pop_i,
  output lbr_pkg::cmd_t        data_o,
  output lbr_pkg::q_stat_t     stat_o
);
  import lbr_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign data_o       = mem_q[rp_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lbr_back.sv =====
// Generator engine: 48-bit LCG stepped by 48x16 partial products, a
// restoring divider for modulo rejection, and the output register.
// Depends on lbr_pkg.
`default_nettype none

module lbr_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmd_valid_i,
  input  lbr_pkg::cmd_t                      cmd_i,
  output logic                               cmd_pop_o,
  input  wire logic                          seed_load_i,
  input  wire logic [lbr_pkg::STATE_BITS-1:0] seed_i,
  input  wire logic [lbr_pkg::STATE_BITS-1:0] mult_i,
  input  wire logic [lbr_pkg::STATE_BITS-1:0] add_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [63:0]                        out_value_o,
  output logic                               out_bad_o,
  output lbr_pkg::back_stat_t                stat_o
);
  import lbr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_EVAL,
    S_DIV,
    S_CHECK
  } state_e;

  state_e                fsm_q;
  cmd_t                  cmd_q;
  logic [STATE_BITS-1:0] state_q, acc_q;
  logic [1:0]            chunk_q;
  logic                  half_q;
  logic [31:0]           hi_q;
  logic [30:0]           raw_q, dsh_q, rem_q;
  logic [4:0]            cnt_q;
  logic [9:0]            tries_q;
  logic                  out_valid_q, out_bad_q;
  logic [63:0]           out_value_q;

  logic [MUL_CHUNK-1:0]  mchunk;
  logic [63:0]           prod;
  logic [STATE_BITS-1:0] part, acc_d;
  logic [31:0]           top32, raw_bits, pow_res, rem_res, rem_sum;
  logic [31:0]           rem_shift, rem_sub;
  logic                  take;

  always_comb begin
    unique case (chunk_q)
      2'd0:    mchunk = mult_i[15:0];
      2'd1:    mchunk = mult_i[31:16];
      default: mchunk = mult_i[47:32];
    endcase
  end

  assign prod  = state_q * mchunk;
  assign part  = prod[STATE_BITS-1:0] << {chunk_q, 4'b0000};
  assign acc_d = acc_q + part;

  assign top32    = state_q[47:16];
  assign raw_bits = (cmd_q.width == 6'd0) ? 32'd0 : (top32 >> (6'd32 - cmd_q.width));
  assign pow_res  = {1'b0, state_q[47:17] >> cmd_q.shamt} + cmd_q.offset;

  assign rem_shift = {rem_q, dsh_q[30]};
  assign rem_sub   = rem_shift - {1'b0, cmd_q.limit};
  assign rem_sum   = {1'b0, raw_q} - {1'b0, rem_q} + {1'b0, cmd_q.limit} - 32'd1;
  assign rem_res   = {1'b0, rem_q} + cmd_q.offset;

  assign take        = (fsm_q == S_IDLE) && cmd_valid_i && !out_valid_q;
  assign cmd_pop_o   = take;
  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_bad_o   = out_bad_q;
  assign stat_o.start = take;
  assign stat_o.busy  = (fsm_q != S_IDLE);

  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= S_IDLE;
      state_q     <= RESET_MULT;
      acc_q       <= '0;
      chunk_q     <= 2'd0;
      half_q      <= 1'b0;
      hi_q        <= '0;
      raw_q       <= '0;
      dsh_q       <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      tries_q     <= '0;
      out_valid_q <= 1'b0;
      out_bad_q   <= 1'b0;
      out_value_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (seed_load_i) state_q <= seed_i ^ mult_i;
      unique case (fsm_q)
        S_IDLE: begin
          if (take) begin
            if (cmd_i.kind == K_CONST) begin
              out_valid_q <= 1'b1;
              out_bad_q   <= cmd_i.bad;
              out_value_q <= {{32{cmd_i.offset[31]}}, cmd_i.offset};
            end else begin
              acc_q   <= add_i;
              chunk_q <= 2'd0;
              half_q  <= 1'b0;
              tries_q <= '0;
              fsm_q   <= S_MUL;
            end
          end
        end
        S_MUL: begin
          acc_q   <= acc_d;
          chunk_q <= chunk_q + 2'd1;
          if (chunk_q == 2'd2) begin
            state_q <= acc_d;
            fsm_q   <= S_EVAL;
          end
        end
        S_EVAL: begin
          unique case (cmd_q.kind)
            K_RAW: begin
              out_valid_q <= 1'b1;
              out_bad_q   <= 1'b0;
              out_value_q <= {{32{raw_bits[31]}}, raw_bits};
              fsm_q       <= S_IDLE;
            end
            K_LONG: begin
              if (!half_q) begin
                hi_q    <= top32;
                half_q  <= 1'b1;
                acc_q   <= add_i;
                chunk_q <= 2'd0;
                fsm_q   <= S_MUL;
              end else begin
                out_valid_q <= 1'b1;
                out_bad_q   <= 1'b0;
                out_value_q <= {hi_q, 32'd0} + {{32{top32[31]}}, top32};
                fsm_q       <= S_IDLE;
              end
            end
            K_LIMIT: begin
              if (cmd_q.pow2) begin
                out_valid_q <= 1'b1;
                out_bad_q   <= 1'b0;
                out_value_q <= {{32{pow_res[31]}}, pow_res};
                fsm_q       <= S_IDLE;
              end else begin
                raw_q <= state_q[47:17];
                dsh_q <= state_q[47:17];
                rem_q <= '0;
                cnt_q <= 5'd30;
                fsm_q <= S_DIV;
              end
            end
            default: fsm_q <= S_IDLE;
          endcase
        end
        S_DIV: begin
          // One quotient bit per cycle; the remainder stays below the limit.
          rem_q <= rem_shift[31] || (rem_shift >= {1'b0, cmd_q.limit}) ?
                   rem_sub[30:0] : rem_shift[30:0];
          dsh_q <= {dsh_q[29:0], 1'b0};
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd0) fsm_q <= S_CHECK;
        end
        S_CHECK: begin
          if (!rem_sum[31] || (tries_q == LAST_TRY)) begin
            out_valid_q <= 1'b1;
            out_bad_q   <= 1'b0;
            out_value_q <= {{32{rem_res[31]}}, rem_res};
            fsm_q       <= S_IDLE;
          end else begin
            tries_q <= tries_q + 10'd1;
            acc_q   <= add_i;
            chunk_q <= 2'd0;
            fsm_q   <= S_MUL;
          end
        end
        default: fsm_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcg48_bounded_random_top.sv =====
// Top level of the lcg48 bounded random generator: configuration registers,
// decoder, command queue and generator engine. Depends on lbr_pkg and all lbr modules.
//
// Usage: requests enter on the s_axis group; tdata carries op, bit_count,
// upper_bound, range_low and range_high. Each request gives exactly one
// result on the m_axis group: tdata is the 64-bit value, tuser the bad-bound
// flag. Registers (seed, multiplier, addend) are written through cfg_we_i,
// cfg_idx_i and cfg_data_i only while the block is idle, a rule for the user
// that the block does not enforce; a seed write reloads the generator with
// seed xor multiplier. A constant result (bad bound, empty range) goes from
// idle straight to the output register; a raw or power-of-two request runs
// one LCG step, a long two. Every LCG step runs through the shared 48x16
// multiplier, and each modulo rejection round adds a divider run plus a
// check. Throughput is one item per engine run. Up to two decoded requests
// wait in the queue while the engine works, so the input keeps accepting
// during receiver stalls until the queue is full; the output register holds
// its result until taken, and the engine waits for it to drain. Reset loads
// the multiplier 0x5DEECE66D, the addend 0xB and the state 0x5DEECE66D, and
// empties the queue and output.
`default_nettype none

module lcg48_bounded_random_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // op[1:0], bit_count[7:2], upper_bound[39:8], range_low[71:40], range_high[103:72]
  input  wire logic [103:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // value[63:0]
  output logic [63:0]       m_axis_tdata,
  // bad_bound[0]
  output logic              m_axis_tuser,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [47:0]  cfg_data_i
);
  import lbr_pkg::*;

  `include "lcg48_bounded_random_top_defines.svh"

  logic [STATE_BITS-1:0] mult_q, add_q;
  cmd_t                  dec_cmd, q_cmd;
  q_stat_t               q_stat;
  back_stat_t            b_stat;
  logic                  push, pop;

  assign s_axis_tready = !q_stat.full;
  assign push          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= RESET_MULT;
      add_q  <= RESET_ADD;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_MULT) mult_q <= cfg_data_i;
      if (cfg_idx_i == REG_ADD) add_q <= cfg_data_i;
    end
  end

  lbr_front u_front (
    .req_i (s_axis_tdata),
    .cmd_o (dec_cmd)
  );

  lbr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (dec_cmd),
    .pop_i  (pop),
    .data_o (q_cmd),
    .stat_o (q_stat)
  );

  lbr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_stat.empty),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (pop),
    .seed_load_i (cfg_we_i && (cfg_idx_i == REG_SEED)),
    .seed_i      (cfg_data_i),
    .mult_i      (mult_q),
    .add_i       (add_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (m_axis_tdata),
    .out_bad_o   (m_axis_tuser),
    .stat_o      (b_stat)
  );

  `LBR_ASSERT_NOW(a_bad_is_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 64'd0)
  `LBR_ASSERT_NOW(a_start_needs_free_out, b_stat.start, !m_axis_tvalid && !b_stat.busy)
  `LBR_ASSERT_NOW(a_pop_needs_entry, pop, !q_stat.empty)
  `LBR_ASSERT_NEXT(a_busy_no_output, b_stat.busy && !m_axis_tvalid && !b_stat.start,
                   !m_axis_tvalid || !b_stat.busy)

endmodule

`default_nettype wire

// ===== dv/lcg48_bounded_random_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking test of the lcg48 bounded random generator top level.
// Depends on lbr_pkg and the lcg48_bounded_random_top RTL; no files are read.

module lcg48_bounded_random_top_test;
  import lbr_pkg::*;

  localparam int unsigned TRY_CAP     = 1024;
  localparam longint      CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [63:0] value;
    logic        bad_bound;
  } rnd_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = REG_SEED;
  logic [47:0]  cfg_data_i = '0;

  // Shadow copy of the generator registers and state.
  logic [47:0] gen_state = RESET_MULT;
  logic [47:0] gen_mult  = RESET_MULT;
  logic [47:0] gen_add   = RESET_ADD;

  rnd_result_t pending_results[$];
  int          mismatches = 0;
  longint      cycles = 0;
  bit          rx_stall_free = 1'b0;

  lcg48_bounded_random_top u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 40) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] next_draw(int unsigned width);
    gen_state = gen_state * gen_mult + gen_add;
    if (width == 0) return 32'd0;
    if (width > 32) width = 32;
    return 32'(gen_state >> (48 - width));
  endfunction

  function automatic logic [63:0] sext32(logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  // Uniform draw below a limit in 1 .. 2^31-1.
  function automatic logic [31:0] uniform_below(logic [31:0] limit);
    logic [31:0] pick, rem;
    logic [63:0] prod;
    int unsigned tries;
    pick = next_draw(31);
    if ((limit & (limit - 1)) == 0) begin
      prod = 64'(limit) * 64'(pick);
      return 32'(prod >> 31);
    end
    tries = 0;
    forever begin
      rem = pick % limit;
      if (((pick - rem + limit - 1) & 32'h8000_0000) == 0) return rem;
      tries++;
      if (tries >= TRY_CAP) return rem;
      pick = next_draw(31);
    end
  endfunction

  function automatic rnd_result_t predict_result(logic [1:0] op, logic [5:0] bit_count,
                                                 logic [31:0] ubound, logic [31:0] lo,
                                                 logic [31:0] hi);
    rnd_result_t r;
    logic [31:0] span, up;
    r = '0;
    case (op)
      OP_RAW: r.value = sext32(next_draw(bit_count));
      OP_LIMIT: begin
        if (ubound == 0 || ubound[31]) r.bad_bound = 1'b1;
        else r.value = sext32(uniform_below(ubound));
      end
      OP_LONG: begin
        up = next_draw(32);
        r.value = {up, 32'd0} + sext32(next_draw(32));
      end
      default: begin
        if ($signed(lo) >= $signed(hi)) begin
          r.value = sext32(lo);
        end else begin
          span = hi - lo + 1;
          if (span == 0 || span[31]) r.bad_bound = 1'b1;
          else r.value = sext32(uniform_below(span) + lo);
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_request(logic [1:0] op, logic [5:0] bit_count, logic [31:0] ubound,
                              logic [31:0] lo, logic [31:0] hi);
    int unsigned gap;
    @(negedge clk_i);
    s_axis_tdata  = {hi, lo, ubound, bit_count, op};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_result(op, bit_count, ubound, lo, hi));
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // The last request may have left tvalid high; drop it before waiting.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Called only while idle; a seed write reloads the state with seed xor multiplier.
  task automatic write_register(logic [1:0] idx, logic [47:0] data);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_SEED: gen_state = data ^ gen_mult;
      REG_MULT: gen_mult  = data;
      default:  gen_add   = data;
    endcase
  endtask

  task automatic send_random_request();
    logic [31:0] ubound, lo, hi;
    logic [5:0]  bit_count;
    int unsigned sel;
    bit_count = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(1, 32));
    sel = $urandom_range(0, 9);
    if (sel < 3)      ubound = $urandom_range(1, 1000);
    else if (sel < 5) ubound = 32'd1 << $urandom_range(0, 30);
    else if (sel < 8) ubound = {1'b0, 31'($urandom)};
    else              ubound = $urandom;
    lo = $urandom;
    sel = $urandom_range(0, 9);
    if (sel < 5)      hi = lo + $urandom_range(1, 5000);
    else if (sel < 7) hi = lo + {1'b0, 31'($urandom)};
    else              hi = $urandom;
    send_request(2'($urandom_range(0, 3)), bit_count, ubound, lo, hi);
  endtask

  task automatic test_directed();
    send_request(OP_RAW, 6'd1, 0, 0, 0);
    send_request(OP_RAW, 6'd32, 0, 0, 0);
    send_request(OP_RAW, 6'd0, '1, '1, '1);
    send_request(OP_RAW, 6'd63, 0, 0, 0);
    send_request(OP_RAW, 6'd33, 0, 0, 0);
    send_request(OP_LIMIT, 0, 32'd1, 0, 0);
    send_request(OP_LIMIT, 0, 32'h4000_0000, 0, 0);
    send_request(OP_LIMIT, 0, 32'h7FFF_FFFF, 0, 0);
    send_request(OP_LIMIT, 0, 32'd6, 0, 0);
    send_request(OP_LIMIT, 0, 32'h5555_5555, 0, 0);
    send_request(OP_LIMIT, 0, 32'd0, 0, 0);
    send_request(OP_LIMIT, 0, 32'h8000_0000, 0, 0);
    send_request(OP_LIMIT, 0, 32'hFFFF_FFFF, 0, 0);
    send_request(OP_LONG, 0, 0, 0, 0);
    send_request(OP_LONG, '1, '1, '1, '1);
    send_request(OP_RANGE, 0, 0, 32'd5, 32'd5);
    send_request(OP_RANGE, 0, 0, 32'd7, 32'hFFFF_FFF0);
    send_request(OP_RANGE, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(OP_RANGE, 0, 0, 32'hC000_0000, 32'h3FFF_FFFF);
    send_request(OP_RANGE, 0, 0, 32'hFFFF_FFF0, 32'd15);
    send_request(OP_RANGE, 0, 0, 32'd0, 32'h7FFF_FFFE);
    send_request(OP_RANGE, 0, 0, 32'h8000_0000, 32'hBFFF_FFFF);
    drain_results();
  endtask

  task automatic test_random_traffic(int unsigned count);
    rx_stall_free = ($urandom_range(0, 3) == 0);
    repeat (count) send_random_request();
    rx_stall_free = 1'b0;
    drain_results();
  endtask

  task automatic test_register_settings();
    write_register(REG_SEED, 48'hFFFF_FFFF_FFFF);
    test_random_traffic(60);
    write_register(REG_MULT, 48'hFFFF_FFFF_FFFF);
    write_register(REG_ADD, 48'hFFFF_FFFF_FFFF);
    test_random_traffic(60);
    // A zero multiplier and addend freeze the state; draws repeat.
    write_register(REG_MULT, 48'd0);
    write_register(REG_ADD, 48'd0);
    write_register(REG_SEED, 48'h1234_5678_9ABC);
    test_random_traffic(30);
    write_register(REG_MULT, $urandom | 48'd1);
    write_register(REG_ADD, {16'($urandom), 32'($urandom)});
    write_register(REG_SEED, {16'($urandom), 32'($urandom)});
    test_random_traffic(60);
    write_register(REG_MULT, RESET_MULT);
    write_register(REG_ADD, RESET_ADD);
    write_register(REG_SEED, 48'd0);
  endtask

  always @(negedge clk_i)
    m_axis_tready <= rx_stall_free ? 1'b1 : (pick_gap() == 0 || $urandom_range(0, 1) == 1);

  always @(posedge clk_i) begin
    rnd_result_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata, m_axis_tuser};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: value %h bad %b",
                                       got.value, got.bad_bound);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: value exp %h got %h, bad exp %b got %b",
                     want.value, got.value, want.bad_bound, got.bad_bound);
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_traffic(240);
    test_register_settings();
    test_random_traffic(240);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== lcg48_bounded_random_top.f =====
+incdir+rtl
rtl/lbr_pkg.sv
rtl/lbr_front.sv
rtl/lbr_queue.sv
rtl/lbr_back.sv
rtl/lcg48_bounded_random_top.sv
dv/lcg48_bounded_random_top_test.sv
